### rtl/core/drm_pkg.sv
// Shared types and constants of the DNS response matcher.
`default_nettype none

package drm_pkg;

   localparam int IdSpace = 65536;
   localparam int IdWidth = $clog2(IdSpace);

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 64;

   localparam logic [CsrIndexWidth-1:0] CSR_REQUEST_COUNT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_INTERVAL = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_START_TIME = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_LIST_SIZE = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_FIRST_SLOT = 3'd5;

   typedef enum logic [2:0] {
      STATUS_SENT = 3'd0,
      STATUS_MATCHED = 3'd1,
      STATUS_DROP_INVALID = 3'd2,
      STATUS_DROP_UNKNOWN = 3'd3,
      STATUS_REFUSED = 3'd4
   } status_type;

   typedef struct packed {
      logic valid;
      logic [31:0] index;
      logic [63:0] send_time;
   } pend_entry_type;

   localparam int PendWidth = $bits(pend_entry_type);

   typedef struct packed {
      logic send;
      logic recv_start;
      logic lookup;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/core/drm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module drm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/drm_ctrl.sv
// Controller state machine of the DNS response matcher.
`default_nettype none

module drm_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_func,
   input wire drm_pkg::dp_status_type status,
   output logic req_stall,
   output drm_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE,
      LOOKUP,
      FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic accept;

   always_comb begin
      req_stall = !((state_ff == IDLE) && status.out_free);
      accept = req_valid && !req_stall;
      cmd.send = accept && !req_func;
      cmd.recv_start = accept && req_func;
      cmd.lookup = (state_ff == LOOKUP);
      cmd.finish = (state_ff == FINISH);
      unique case (state_ff)
         IDLE: begin
            state_in = cmd.recv_start ? LOOKUP : IDLE;
         end
         LOOKUP: begin
            state_in = FINISH;
         end
         FINISH: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/drm_datapath.sv
// Datapath of the DNS response matcher: registers, counters, pending table, result register.
`default_nettype none

module drm_datapath (
   input wire logic clock,
   input wire logic reset,
   input wire drm_pkg::ctrl_cmd_type cmd,
   output drm_pkg::dp_status_type status,
   input wire logic [15:0] req_tx_id,
   input wire logic [15:0] req_question_count,
   input wire logic req_is_response,
   input wire logic [3:0] req_response_code,
   input wire logic [15:0] req_answer_count,
   input wire logic [63:0] req_receive_time_ns,
   input wire logic csr_write_enable,
   input wire logic [drm_pkg::CsrIndexWidth-1:0] csr_index,
   input wire logic [drm_pkg::CsrDataWidth-1:0] csr_write_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_out_tx_id,
   output logic [31:0] rsp_query_index,
   output logic [23:0] rsp_query_slot,
   output logic [63:0] rsp_send_time_ns,
   output logic signed [63:0] rsp_round_trip_ns,
   output logic rsp_answered
);

   // Configuration and running send state.
   logic [31:0] request_count_ff, request_count_in;
   logic [31:0] interval_ff, interval_in;
   logic [39:0] timeout_ff, timeout_in;
   logic [23:0] list_size_ff, list_size_in;
   logic [31:0] sent_count_ff, sent_count_in;
   logic [63:0] next_send_time_ff, next_send_time_in;
   logic [23:0] current_slot_ff, current_slot_in;

   // Receive beat held across the lookup.
   logic [15:0] rx_id_ff, rx_id_in;
   logic qd_nonzero_ff, qd_nonzero_in;
   logic hdr_ok_ff, hdr_ok_in;
   logic known_ff, known_in;
   logic [63:0] rx_time_ff, rx_time_in;
   logic hit_ff, hit_in;
   logic [31:0] hit_index_ff, hit_index_in;
   logic [63:0] hit_time_ff, hit_time_in;
   logic [63:0] rtt_ff, rtt_in;

   // Result register.
   logic out_valid_ff, out_valid_in;
   logic [2:0] out_status_ff, out_status_in;
   logic [15:0] out_tx_id_ff, out_tx_id_in;
   logic [31:0] out_index_ff, out_index_in;
   logic [23:0] out_slot_ff, out_slot_in;
   logic [63:0] out_send_time_ff, out_send_time_in;
   logic [63:0] out_rtt_ff, out_rtt_in;
   logic out_answered_ff, out_answered_in;

   logic [23:0] size;
   logic [23:0] slot_now;
   logic [23:0] slot_next;
   logic refused;
   logic ever_written;
   logic in_time;
   logic load_out;

   logic ram_wr_en;
   logic [drm_pkg::IdWidth-1:0] ram_wr_addr;
   drm_pkg::pend_entry_type ram_wr_entry;
   logic [drm_pkg::PendWidth-1:0] ram_rd_data;
   drm_pkg::pend_entry_type ram_rd_entry;

   drm_ram #(
      .WIDTH(drm_pkg::PendWidth),
      .DEPTH(drm_pkg::IdSpace)
   ) u_pend_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en(cmd.recv_start),
      .rd_addr(req_tx_id[drm_pkg::IdWidth-1:0]),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      ram_rd_entry = drm_pkg::pend_entry_type'(ram_rd_data);
      status.out_free = !out_valid_ff || !rsp_stall;

      size = (list_size_ff == '0) ? 24'd1 : list_size_ff;
      slot_now = (current_slot_ff < size) ? current_slot_ff : '0;
      slot_next = slot_now + 24'd1;
      refused = (sent_count_ff >= request_count_ff);

      // An entry has been written at least once exactly when the send count has passed its ID.
      ever_written = ((sent_count_ff >> drm_pkg::IdWidth) != '0)
         || (sent_count_ff[drm_pkg::IdWidth-1:0] > req_tx_id[drm_pkg::IdWidth-1:0]);

      in_time = rtt_ff[63] || (rtt_ff < 64'(timeout_ff));

      // Configuration writes.
      request_count_in = request_count_ff;
      interval_in = interval_ff;
      timeout_in = timeout_ff;
      list_size_in = list_size_ff;
      sent_count_in = sent_count_ff;
      next_send_time_in = next_send_time_ff;
      current_slot_in = current_slot_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            drm_pkg::CSR_REQUEST_COUNT: begin
               request_count_in = csr_write_data[31:0];
            end
            drm_pkg::CSR_INTERVAL: begin
               interval_in = csr_write_data[31:0];
            end
            drm_pkg::CSR_START_TIME: begin
               next_send_time_in = csr_write_data;
            end
            drm_pkg::CSR_TIMEOUT: begin
               timeout_in = csr_write_data[39:0];
            end
            drm_pkg::CSR_LIST_SIZE: begin
               list_size_in = csr_write_data[23:0];
            end
            drm_pkg::CSR_FIRST_SLOT: begin
               current_slot_in = csr_write_data[23:0];
            end
            default: begin
            end
         endcase
      end else if (cmd.send && !refused) begin
         sent_count_in = sent_count_ff + 32'd1;
         next_send_time_in = next_send_time_ff + 64'(interval_ff);
         current_slot_in = (slot_next >= size) ? '0 : slot_next;
      end

      // Receive capture and lookup.
      rx_id_in = rx_id_ff;
      qd_nonzero_in = qd_nonzero_ff;
      hdr_ok_in = hdr_ok_ff;
      known_in = known_ff;
      rx_time_in = rx_time_ff;
      if (cmd.recv_start) begin
         rx_id_in = req_tx_id;
         qd_nonzero_in = (req_question_count != '0);
         hdr_ok_in = req_is_response && (req_response_code == '0)
            && (req_answer_count != '0);
         known_in = ((req_tx_id >> drm_pkg::IdWidth) == '0) && ever_written;
         rx_time_in = req_receive_time_ns;
      end
      hit_in = hit_ff;
      hit_index_in = hit_index_ff;
      hit_time_in = hit_time_ff;
      rtt_in = rtt_ff;
      if (cmd.lookup) begin
         hit_in = known_ff && ram_rd_entry.valid;
         hit_index_in = ram_rd_entry.index;
         hit_time_in = ram_rd_entry.send_time;
         rtt_in = rx_time_ff - ram_rd_entry.send_time;
      end

      // Pending table writes: a send records, a match clears.
      ram_wr_en = 1'b0;
      ram_wr_addr = sent_count_ff[drm_pkg::IdWidth-1:0];
      ram_wr_entry.valid = 1'b1;
      ram_wr_entry.index = sent_count_ff;
      ram_wr_entry.send_time = next_send_time_ff;
      if (cmd.send) begin
         ram_wr_en = !refused;
      end else if (cmd.finish) begin
         ram_wr_en = qd_nonzero_ff && hit_ff;
         ram_wr_addr = rx_id_ff[drm_pkg::IdWidth-1:0];
         ram_wr_entry.valid = 1'b0;
         ram_wr_entry.index = hit_index_ff;
         ram_wr_entry.send_time = hit_time_ff;
      end

      // Result register.
      load_out = cmd.send || cmd.finish;
      out_valid_in = load_out || (out_valid_ff && rsp_stall);
      out_status_in = out_status_ff;
      out_tx_id_in = out_tx_id_ff;
      out_index_in = out_index_ff;
      out_slot_in = out_slot_ff;
      out_send_time_in = out_send_time_ff;
      out_rtt_in = out_rtt_ff;
      out_answered_in = out_answered_ff;
      if (load_out) begin
         out_tx_id_in = '0;
         out_index_in = '0;
         out_slot_in = '0;
         out_send_time_in = '0;
         out_rtt_in = '0;
         out_answered_in = 1'b0;
         if (cmd.send) begin
            if (refused) begin
               out_status_in = drm_pkg::STATUS_REFUSED;
            end else begin
               out_status_in = drm_pkg::STATUS_SENT;
               out_tx_id_in = 16'(sent_count_ff[drm_pkg::IdWidth-1:0]);
               out_index_in = sent_count_ff;
               out_slot_in = slot_now;
               out_send_time_in = next_send_time_ff;
            end
         end else begin
            out_tx_id_in = rx_id_ff;
            if (!qd_nonzero_ff) begin
               out_status_in = drm_pkg::STATUS_DROP_INVALID;
            end else if (!hit_ff) begin
               out_status_in = drm_pkg::STATUS_DROP_UNKNOWN;
            end else begin
               out_status_in = drm_pkg::STATUS_MATCHED;
               out_index_in = hit_index_ff;
               out_send_time_in = hit_time_ff;
               out_rtt_in = rtt_ff;
               out_answered_in = hdr_ok_ff && in_time;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_count_ff <= '0;
         interval_ff <= 32'd1000;
         timeout_ff <= 40'd1000000000;
         list_size_ff <= 24'd1;
         sent_count_ff <= '0;
         next_send_time_ff <= '0;
         current_slot_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         request_count_ff <= request_count_in;
         interval_ff <= interval_in;
         timeout_ff <= timeout_in;
         list_size_ff <= list_size_in;
         sent_count_ff <= sent_count_in;
         next_send_time_ff <= next_send_time_in;
         current_slot_ff <= current_slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_id_ff <= rx_id_in;
      qd_nonzero_ff <= qd_nonzero_in;
      hdr_ok_ff <= hdr_ok_in;
      known_ff <= known_in;
      rx_time_ff <= rx_time_in;
      hit_ff <= hit_in;
      hit_index_ff <= hit_index_in;
      hit_time_ff <= hit_time_in;
      rtt_ff <= rtt_in;
      out_status_ff <= out_status_in;
      out_tx_id_ff <= out_tx_id_in;
      out_index_ff <= out_index_in;
      out_slot_ff <= out_slot_in;
      out_send_time_ff <= out_send_time_in;
      out_rtt_ff <= out_rtt_in;
      out_answered_ff <= out_answered_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_out_tx_id = out_tx_id_ff;
   assign rsp_query_index = out_index_ff;
   assign rsp_query_slot = out_slot_ff;
   assign rsp_send_time_ns = out_send_time_ff;
   assign rsp_round_trip_ns = $signed(out_rtt_ff);
   assign rsp_answered = out_answered_ff;

endmodule

`default_nettype wire

### rtl/core/dns_response_matcher_unit.sv
// Top level of the DNS response matcher.
// A send beat claims the next query number and transaction ID, writes the pending table and
// loads the result register in the cycle it is accepted. A response beat goes through a
// registered read of the 65536-entry pending table, the 64-bit round-trip subtraction, then
// the timeout compare together with the table write that clears the entry.
// The next request beat is taken once the block is idle and the result register is free or being
// drained in the same cycle. The table needs no clearing pass after reset: an entry counts as
// written only once the send count has passed its transaction ID.
`default_nettype none

module dns_response_matcher_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_func,
   input wire logic [15:0] req_tx_id,
   input wire logic [15:0] req_question_count,
   input wire logic req_is_response,
   input wire logic [3:0] req_response_code,
   input wire logic [15:0] req_answer_count,
   input wire logic [63:0] req_receive_time_ns,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_out_tx_id,
   output logic [31:0] rsp_query_index,
   output logic [23:0] rsp_query_slot,
   output logic [63:0] rsp_send_time_ns,
   output logic signed [63:0] rsp_round_trip_ns,
   output logic rsp_answered,
   input wire logic csr_write_enable,
   input wire logic [drm_pkg::CsrIndexWidth-1:0] csr_index,
   input wire logic [drm_pkg::CsrDataWidth-1:0] csr_write_data
);

   drm_pkg::ctrl_cmd_type cmd;
   drm_pkg::dp_status_type status;

   drm_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_func(req_func),
      .status(status),
      .req_stall(req_stall),
      .cmd(cmd)
   );

   drm_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_tx_id(req_tx_id),
      .req_question_count(req_question_count),
      .req_is_response(req_is_response),
      .req_response_code(req_response_code),
      .req_answer_count(req_answer_count),
      .req_receive_time_ns(req_receive_time_ns),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_tx_id(rsp_out_tx_id),
      .rsp_query_index(rsp_query_index),
      .rsp_query_slot(rsp_query_slot),
      .rsp_send_time_ns(rsp_send_time_ns),
      .rsp_round_trip_ns(rsp_round_trip_ns),
      .rsp_answered(rsp_answered)
   );

endmodule

`default_nettype wire

### rtl/core/drm_checker.sv
// Port-level assertions of the DNS response matcher and their binding to the top level.
`default_nettype none

module drm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic req_func,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [2:0] rsp_status,
   input wire logic [31:0] rsp_query_index,
   input wire logic [63:0] rsp_send_time_ns,
   input wire logic signed [63:0] rsp_round_trip_ns,
   input wire logic rsp_answered
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result beat changed");

   a_send_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_func |=> rsp_valid)
      else $error("send beat gave no result in the next cycle");

   a_recv_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func |=> !rsp_valid ##1 !rsp_valid ##1 rsp_valid)
      else $error("response beat result out of place");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request beat taken while result register is blocked");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == drm_pkg::STATUS_SENT
         || rsp_status == drm_pkg::STATUS_DROP_INVALID
         || rsp_status == drm_pkg::STATUS_DROP_UNKNOWN
         || rsp_status == drm_pkg::STATUS_REFUSED)
      |-> rsp_round_trip_ns == '0 && !rsp_answered
         && (rsp_status == drm_pkg::STATUS_SENT
            || (rsp_query_index == '0 && rsp_send_time_ns == '0)))
      else $error("result field not cleared for its status");

endmodule

bind dns_response_matcher_unit drm_checker u_drm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_func(req_func),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_status(rsp_status),
   .rsp_query_index(rsp_query_index),
   .rsp_send_time_ns(rsp_send_time_ns),
   .rsp_round_trip_ns(rsp_round_trip_ns),
   .rsp_answered(rsp_answered)
);

`default_nettype wire

### test/tb_dns_response_matcher_unit.sv
// Testbench for the DNS response matcher: random send and response beats against a predictor.
`timescale 1ns / 100ps

module tb_dns_response_matcher_unit;

   localparam logic FUNC_SEND = 1'b0;
   localparam logic FUNC_RECEIVE = 1'b1;
   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      logic func;
      logic [15:0] tx_id;
      logic [15:0] question_count;
      logic is_response;
      logic [3:0] response_code;
      logic [15:0] answer_count;
      logic [63:0] receive_time;
   } dns_event_type;

   typedef struct {
      drm_pkg::status_type status;
      logic [15:0] tx_id;
      logic [31:0] query_index;
      logic [23:0] query_slot;
      logic [63:0] send_time;
      logic [63:0] round_trip;
      logic answered;
   } match_outcome_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_func;
   logic [15:0] req_tx_id;
   logic [15:0] req_question_count;
   logic req_is_response;
   logic [3:0] req_response_code;
   logic [15:0] req_answer_count;
   logic [63:0] req_receive_time_ns;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_status;
   logic [15:0] rsp_out_tx_id;
   logic [31:0] rsp_query_index;
   logic [23:0] rsp_query_slot;
   logic [63:0] rsp_send_time_ns;
   logic signed [63:0] rsp_round_trip_ns;
   logic rsp_answered;
   logic csr_write_enable;
   logic [drm_pkg::CsrIndexWidth-1:0] csr_index;
   logic [drm_pkg::CsrDataWidth-1:0] csr_write_data;

   // Register copies and query tracking state of the predictor.
   bit [31:0] quota = 32'd0;
   bit [31:0] pace_ns = 32'd1000;
   bit [39:0] timeout_limit = 40'd1000000000;
   bit [23:0] list_len = 24'd1;
   bit [31:0] sent_total = 32'd0;
   bit [63:0] next_tx_time = 64'd0;
   bit [23:0] slot_cursor = 24'd0;
   bit id_live [drm_pkg::IdSpace];
   bit [31:0] id_query [drm_pkg::IdSpace];
   bit [63:0] id_tx_time [drm_pkg::IdSpace];

   // Stimulus-side view of the schedule, used to aim responses at live IDs.
   bit [31:0] plan_count = 32'd0;
   bit [63:0] plan_time = 64'd0;
   bit [63:0] planned_time [drm_pkg::IdSpace];

   dns_event_type beats_to_send[$];
   match_outcome_type awaited_outcomes[$];
   bit pacing = 1'b1;
   bit req_taken = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int results_seen = 0;
   int error_count = 0;

   dns_response_matcher_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_tx_id(req_tx_id),
      .req_question_count(req_question_count),
      .req_is_response(req_is_response),
      .req_response_code(req_response_code),
      .req_answer_count(req_answer_count),
      .req_receive_time_ns(req_receive_time_ns),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_tx_id(rsp_out_tx_id),
      .rsp_query_index(rsp_query_index),
      .rsp_query_slot(rsp_query_slot),
      .rsp_send_time_ns(rsp_send_time_ns),
      .rsp_round_trip_ns(rsp_round_trip_ns),
      .rsp_answered(rsp_answered),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("tb: %s wrong at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
   endtask

   task automatic enqueue_beat(input dns_event_type ev);
      beats_to_send = {beats_to_send, ev};
   endtask

   task automatic track_dns_event(input dns_event_type ev, output match_outcome_type res);
      bit [31:0] size;
      bit [31:0] slot;
      bit [drm_pkg::IdWidth-1:0] id;
      bit [63:0] rtt;
      bit in_time;
      res.status = drm_pkg::STATUS_SENT;
      res.tx_id = '0;
      res.query_index = '0;
      res.query_slot = '0;
      res.send_time = '0;
      res.round_trip = '0;
      res.answered = 1'b0;
      if (ev.func == FUNC_SEND) begin
         if (sent_total >= quota) begin
            res.status = drm_pkg::STATUS_REFUSED;
         end else begin
            size = (list_len == 24'd0) ? 32'd1 : {8'd0, list_len};
            slot = ({8'd0, slot_cursor} < size) ? {8'd0, slot_cursor} : 32'd0;
            id = sent_total[drm_pkg::IdWidth-1:0];
            id_live[id] = 1'b1;
            id_query[id] = sent_total;
            id_tx_time[id] = next_tx_time;
            res.tx_id = id;
            res.query_index = sent_total;
            res.query_slot = slot[23:0];
            res.send_time = next_tx_time;
            sent_total = sent_total + 32'd1;
            next_tx_time = next_tx_time + {32'd0, pace_ns};
            slot = slot + 32'd1;
            slot_cursor = (slot >= size) ? 24'd0 : slot[23:0];
         end
      end else begin
         id = ev.tx_id;
         res.tx_id = ev.tx_id;
         if (ev.question_count == 16'd0) begin
            res.status = drm_pkg::STATUS_DROP_INVALID;
         end else if (!id_live[id]) begin
            res.status = drm_pkg::STATUS_DROP_UNKNOWN;
         end else begin
            rtt = ev.receive_time - id_tx_time[id];
            in_time = rtt[63] || (rtt < {24'd0, timeout_limit});
            id_live[id] = 1'b0;
            res.status = drm_pkg::STATUS_MATCHED;
            res.query_index = id_query[id];
            res.send_time = id_tx_time[id];
            res.round_trip = rtt;
            res.answered = ev.is_response && (ev.response_code == 4'd0)
                           && (ev.answer_count != 16'd0) && in_time;
         end
      end
   endtask

   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic dns_event_type random_fields();
      dns_event_type ev;
      ev.func = FUNC_RECEIVE;
      ev.tx_id = 16'($urandom);
      ev.question_count = 16'($urandom);
      ev.is_response = 1'($urandom);
      ev.response_code = 4'($urandom);
      ev.answer_count = 16'($urandom);
      ev.receive_time = {$urandom, $urandom};
      return ev;
   endfunction

   task automatic write_register(input logic [drm_pkg::CsrIndexWidth-1:0] idx,
                                 input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         drm_pkg::CSR_REQUEST_COUNT: quota = value[31:0];
         drm_pkg::CSR_INTERVAL: pace_ns = value[31:0];
         drm_pkg::CSR_START_TIME: next_tx_time = value;
         drm_pkg::CSR_TIMEOUT: timeout_limit = value[39:0];
         drm_pkg::CSR_LIST_SIZE: list_len = value[23:0];
         drm_pkg::CSR_FIRST_SLOT: slot_cursor = value[23:0];
         default: ;
      endcase
      plan_count = sent_total;
      plan_time = next_tx_time;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (beats_to_send.size() != 0 || req_valid || awaited_outcomes.size() != 0);
   endtask

   task automatic queue_send();
      dns_event_type ev;
      ev = random_fields();
      ev.func = FUNC_SEND;
      if (plan_count < quota) begin
         planned_time[plan_count[drm_pkg::IdWidth-1:0]] = plan_time;
         plan_time = plan_time + {32'd0, pace_ns};
         plan_count = plan_count + 32'd1;
      end
      enqueue_beat(ev);
   endtask

   task automatic queue_receive(input logic [15:0] id, input logic [15:0] qd, input logic qr,
                                input logic [3:0] rcode, input logic [15:0] an,
                                input logic [63:0] rx_time);
      dns_event_type ev;
      ev.func = FUNC_RECEIVE;
      ev.tx_id = id;
      ev.question_count = qd;
      ev.is_response = qr;
      ev.response_code = rcode;
      ev.answer_count = an;
      ev.receive_time = rx_time;
      enqueue_beat(ev);
   endtask

   // Mostly sends and well-formed responses to recent queries, with some noise mixed in.
   task automatic queue_traffic(input int count);
      int pick;
      int flaw;
      logic [15:0] id;
      logic [15:0] qd;
      logic qr;
      logic [3:0] rcode;
      logic [15:0] an;
      logic [63:0] delta;
      dns_event_type ev;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            queue_send();
         end else if (pick < 88) begin
            id = plan_count[15:0] - 16'($urandom_range(1, 12));
            qd = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom_range(1, 65535));
            qr = 1'b1;
            rcode = 4'd0;
            an = 16'($urandom_range(1, 65535));
            case ($urandom_range(0, 9))
               6: delta = {24'd0, timeout_limit};
               7: delta = {24'd0, timeout_limit} - 64'd1;
               8: delta = -64'($urandom_range(1, 100000));
               9: delta = {$urandom, $urandom};
               default: delta = (timeout_limit == 40'd0) ? 64'($urandom_range(0, 50))
                                : {$urandom, $urandom} % {24'd0, timeout_limit};
            endcase
            flaw = $urandom_range(0, 19);
            if (flaw == 0) qr = 1'b0;
            if (flaw == 1) rcode = 4'($urandom_range(1, 15));
            if (flaw == 2) an = 16'd0;
            if (flaw == 3) qd = 16'd0;
            queue_receive(id, qd, qr, rcode, an, planned_time[id] + delta);
         end else begin
            ev = random_fields();
            if ($urandom_range(0, 3) == 0) ev.question_count = 16'd0;
            enqueue_beat(ev);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin : drive_requests
      dns_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (beats_to_send.size() != 0) begin
            ev = beats_to_send.pop_front();
            req_func <= ev.func;
            req_tx_id <= ev.tx_id;
            req_question_count <= ev.question_count;
            req_is_response <= ev.is_response;
            req_response_code <= ev.response_code;
            req_answer_count <= ev.answer_count;
            req_receive_time_ns <= ev.receive_time;
            req_valid <= 1'b1;
            gap_left = pacing ? pick_pause() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_result_stall
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = (pacing && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
      end
   end

   always @(posedge clock) begin : predict_outcomes
      dns_event_type ev;
      match_outcome_type res;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         ev.func = req_func;
         ev.tx_id = req_tx_id;
         ev.question_count = req_question_count;
         ev.is_response = req_is_response;
         ev.response_code = req_response_code;
         ev.answer_count = req_answer_count;
         ev.receive_time = req_receive_time_ns;
         track_dns_event(ev, res);
         awaited_outcomes = {awaited_outcomes, res};
      end
   end

   always @(posedge clock) begin : check_results
      match_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("beat with nothing pending, status", rsp_status, 64'd0);
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_out_tx_id !== want.tx_id) report_mismatch("tx_id", rsp_out_tx_id, want.tx_id);
            if (rsp_query_index !== want.query_index)
               report_mismatch("query_index", rsp_query_index, want.query_index);
            if (rsp_query_slot !== want.query_slot)
               report_mismatch("query_slot", rsp_query_slot, want.query_slot);
            if (rsp_send_time_ns !== want.send_time)
               report_mismatch("send_time", rsp_send_time_ns, want.send_time);
            if (rsp_round_trip_ns !== want.round_trip)
               report_mismatch("round_trip", rsp_round_trip_ns, want.round_trip);
            if (rsp_answered !== want.answered)
               report_mismatch("answered", rsp_answered, want.answered);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_dns_response_matcher_unit: done, errors");
            $finish;
         end
      end
   end

   initial begin
      logic [23:0] size_pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_SEND;
      req_tx_id = '0;
      req_question_count = '0;
      req_is_response = 1'b0;
      req_response_code = '0;
      req_answer_count = '0;
      req_receive_time_ns = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = drm_pkg::CSR_REQUEST_COUNT;
      csr_write_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset quota of zero every send is refused.
      queue_send();
      queue_receive(16'h0000, 16'd1, 1'b1, 4'd0, 16'd1, 64'd0);
      queue_receive(16'h0000, 16'd0, 1'b1, 4'd0, 16'd1, 64'd0);
      wait_drained();

      write_register(drm_pkg::CSR_REQUEST_COUNT, 64'hFFFF_FFFF);
      write_register(drm_pkg::CSR_INTERVAL, 64'd250);
      write_register(drm_pkg::CSR_START_TIME, 64'h0000_0001_0000_0000);
      write_register(drm_pkg::CSR_TIMEOUT, 64'd5000);
      write_register(drm_pkg::CSR_LIST_SIZE, 64'd3);
      write_register(drm_pkg::CSR_FIRST_SLOT, 64'd2);
      repeat (6) queue_send();
      queue_receive(16'd0, 16'd1, 1'b1, 4'd0, 16'd1, planned_time[0] + 64'd100);
      queue_receive(16'd1, 16'hFFFF, 1'b0, 4'd0, 16'hFFFF, planned_time[1] + 64'd100);
      queue_receive(16'd2, 16'd1, 1'b1, 4'hF, 16'd1, planned_time[2] + 64'd100);
      queue_receive(16'd3, 16'd1, 1'b1, 4'd0, 16'd0, planned_time[3] + 64'd100);
      queue_receive(16'd1, 16'd1, 1'b1, 4'd0, 16'd1, planned_time[1] + 64'd100);
      queue_receive(16'hFFFF, 16'hFFFF, 1'b1, 4'd0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      repeat (3) queue_send();
      queue_receive(16'd6, 16'd1, 1'b1, 4'd0, 16'd1, planned_time[6] + 64'd5000);
      queue_receive(16'd7, 16'd1, 1'b1, 4'd0, 16'd1, planned_time[7] + 64'd4999);
      queue_receive(16'd8, 16'd1, 1'b1, 4'd0, 16'd1, 64'd0);
      wait_drained();

      write_register(drm_pkg::CSR_INTERVAL, 64'($urandom_range(1, 5000)));
      write_register(drm_pkg::CSR_START_TIME, {$urandom, $urandom});
      write_register(drm_pkg::CSR_TIMEOUT, 64'($urandom_range(1000, 200000)));
      write_register(drm_pkg::CSR_LIST_SIZE, 64'd7);
      write_register(drm_pkg::CSR_FIRST_SLOT, 64'd5);
      queue_traffic(100);
      wait_drained();
      queue_traffic(100);
      wait_drained();

      write_register(drm_pkg::CSR_INTERVAL, 64'd0);
      write_register(drm_pkg::CSR_LIST_SIZE, 64'd0);
      write_register(drm_pkg::CSR_FIRST_SLOT, 64'hFF_FFFE);
      write_register(drm_pkg::CSR_TIMEOUT, 64'd0);
      queue_traffic(150);
      wait_drained();

      write_register(drm_pkg::CSR_INTERVAL, {$urandom, 32'hFFFF_FFFF});
      write_register(drm_pkg::CSR_START_TIME, 64'hFFFF_FFFF_FFFF_F000);
      write_register(drm_pkg::CSR_TIMEOUT, {24'($urandom), 40'hFF_FFFF_FFFF});
      write_register(drm_pkg::CSR_LIST_SIZE, {$urandom, 8'($urandom), 24'hFF_FFFF});
      write_register(drm_pkg::CSR_FIRST_SLOT, 64'hFF_FFFE);
      pacing = 1'b0;
      queue_traffic(100);
      wait_drained();
      pacing = 1'b1;
      queue_traffic(100);
      wait_drained();

      size_pick = 24'($urandom_range(1, 1000));
      write_register(drm_pkg::CSR_REQUEST_COUNT, {32'd0, sent_total + 32'd20});
      write_register(drm_pkg::CSR_INTERVAL, 64'($urandom_range(1, 100000)));
      write_register(drm_pkg::CSR_LIST_SIZE, {40'd0, size_pick});
      write_register(drm_pkg::CSR_FIRST_SLOT, 64'($urandom_range(0, size_pick - 1)));
      write_register(drm_pkg::CSR_TIMEOUT, {24'd0, 8'($urandom), $urandom});
      queue_traffic(150);
      wait_drained();

      write_register(drm_pkg::CSR_REQUEST_COUNT, 64'd0);
      write_register(drm_pkg::CSR_START_TIME, 64'd0);
      write_register(drm_pkg::CSR_LIST_SIZE, 64'd1);
      write_register(drm_pkg::CSR_FIRST_SLOT, 64'd0);
      queue_traffic(100);
      wait_drained();

      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_dns_response_matcher_unit: done, clean");
      end else begin
         $display("tb_dns_response_matcher_unit: done, errors");
      end
      $finish;
   end

endmodule
